FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held.
`define LCA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lca assertion failed");

// Clocked property that also holds across reset.
`define LCA_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lca assertion failed");

`endif

FILE: rtl/lca_pkg.sv
// Shared constants and control types for the lowest common ancestor block.
`default_nettype none
package lca_pkg;
    localparam int NODE_W = 11;
    localparam int CFG_W  = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_ROOT_NODE  = 1'b1;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic head_we;
        logic slot_we;
        logic stk_we;
    } t_edge_we;

    typedef struct packed {
        logic depth_we;
        logic anc_we;
        logic clear;
    } t_tree_we;
endpackage
`default_nettype wire

FILE: rtl/lca_in_if.sv
// Request channel: edge loads and ancestor queries.
`default_nettype none
interface lca_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [lca_pkg::NODE_W-1:0] node_a;
    logic [lca_pkg::NODE_W-1:0] node_b;
    modport source (output valid, op, node_a, node_b, input ready);
    modport sink (input valid, op, node_a, node_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/lca_out_if.sv
// Result channel: lowest common ancestor of a query.
`default_nettype none
interface lca_out_if;
    logic                       valid;
    logic                       ready;
    logic [lca_pkg::NODE_W-1:0] ancestor_node;
    modport source (output valid, ancestor_node, input ready);
    modport sink (input valid, ancestor_node, output ready);
endinterface
`default_nettype wire

FILE: rtl/lca_binary_lifting_top.sv
// Top level: lowest common ancestor by binary lifting over a loaded tree.
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        op, node_a, node_b
//  o_out    out  valid/ready        ancestor_node
//  apb      in   psel/penable       paddr, pwdata, prdata (node_count, root_node)
//
// An edge writes two adjacency slots; a dropped edge leaves the sequencer idle. A query on
// built tables lifts the deeper node, ends early on a match, else descends the levels.
// The first query after an edge or register write rebuilds: it clears the tables,
// walks the adjacency slots with backtracking, then fills the ancestor levels.
// After reset the head lists are cleared with i_in.ready low.
// A result waiting in the output register holds the sequencer until taken.
`default_nettype none
module lca_binary_lifting_top #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    lca_in_if.sink                       i_in,
    lca_out_if.source                    o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [lca_pkg::APB_AW-1:0]   paddr,
    input  wire  [lca_pkg::APB_DW-1:0]   pwdata,
    output logic [lca_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    localparam int AW  = $clog2(MAX_NODES + 1);
    localparam int LW  = $clog2(2 * MAX_NODES) + 1;
    localparam int SW  = $clog2(2 * MAX_NODES);
    localparam int KW  = $clog2(MAX_NODES);
    localparam int EW  = 2 * AW + LW;
    localparam int LVW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;

    logic [lca_pkg::CFG_W-1:0]  r_node_count, r_root_node;
    logic                       r_out_valid;
    logic [lca_pkg::NODE_W-1:0] r_out_node;
    logic                       cfg_wr, out_free, res_load;
    logic [lca_pkg::NODE_W-1:0] res_node;

    lca_pkg::t_edge_we edge_we;
    lca_pkg::t_tree_we tree_we;
    logic [AW-1:0]  head_waddr, head_raddr, target_wdata, target_rdata;
    logic [LW-1:0]  head_wdata, head_rdata, link_wdata, link_rdata;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic [KW-1:0]  stk_waddr, stk_raddr;
    logic [EW-1:0]  stk_wdata, stk_rdata;
    logic [AW-1:0]  depth_waddr, depth_wdata, depth_raddr_a, depth_raddr_b;
    logic [AW-1:0]  depth_rdata_a, depth_rdata_b;
    logic [LVW-1:0] anc_wlvl, anc_rlvl;
    logic [AW-1:0]  anc_waddr, anc_wdata, anc_raddr_a, anc_raddr_b;
    logic [AW-1:0]  anc_rdata_a, anc_rdata_b;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            lca_pkg::REG_NODE_COUNT: prdata = lca_pkg::APB_DW'(r_node_count);
            lca_pkg::REG_ROOT_NODE:  prdata = lca_pkg::APB_DW'(r_root_node);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= lca_pkg::CFG_W'(1);
            r_root_node  <= lca_pkg::CFG_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == lca_pkg::REG_NODE_COUNT) begin
                r_node_count <= pwdata[lca_pkg::CFG_W-1:0];
            end else begin
                r_root_node <= pwdata[lca_pkg::CFG_W-1:0];
            end
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_node <= res_node;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ancestor_node = r_out_node;

    lca_seq #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready), .i_op(i_in.op),
        .i_node_a(i_in.node_a), .i_node_b(i_in.node_b),
        .i_node_count(r_node_count), .i_root_node(r_root_node), .i_cfg_wr(cfg_wr),
        .i_out_free(out_free), .o_res_load(res_load), .o_res_node(res_node),
        .o_edge_we(edge_we),
        .o_head_waddr(head_waddr), .o_head_wdata(head_wdata),
        .o_head_raddr(head_raddr), .i_head_rdata(head_rdata),
        .o_slot_waddr(slot_waddr), .o_target_wdata(target_wdata),
        .o_link_wdata(link_wdata), .o_slot_raddr(slot_raddr),
        .i_target_rdata(target_rdata), .i_link_rdata(link_rdata),
        .o_stk_waddr(stk_waddr), .o_stk_wdata(stk_wdata),
        .o_stk_raddr(stk_raddr), .i_stk_rdata(stk_rdata),
        .o_tree_we(tree_we),
        .o_depth_waddr(depth_waddr), .o_depth_wdata(depth_wdata),
        .o_depth_raddr_a(depth_raddr_a), .o_depth_raddr_b(depth_raddr_b),
        .i_depth_rdata_a(depth_rdata_a), .i_depth_rdata_b(depth_rdata_b),
        .o_anc_wlvl(anc_wlvl), .o_anc_waddr(anc_waddr), .o_anc_wdata(anc_wdata),
        .o_anc_rlvl(anc_rlvl), .o_anc_raddr_a(anc_raddr_a),
        .o_anc_raddr_b(anc_raddr_b),
        .i_anc_rdata_a(anc_rdata_a), .i_anc_rdata_b(anc_rdata_b)
    );

    lca_edge_mem #(.MAX_NODES(MAX_NODES)) u_edge_mem (
        .i_clk(i_clk), .i_we(edge_we),
        .i_head_waddr(head_waddr), .i_head_wdata(head_wdata),
        .i_head_raddr(head_raddr), .o_head_rdata(head_rdata),
        .i_slot_waddr(slot_waddr), .i_target_wdata(target_wdata),
        .i_link_wdata(link_wdata), .i_slot_raddr(slot_raddr),
        .o_target_rdata(target_rdata), .o_link_rdata(link_rdata),
        .i_stk_waddr(stk_waddr), .i_stk_wdata(stk_wdata),
        .i_stk_raddr(stk_raddr), .o_stk_rdata(stk_rdata)
    );

    lca_tree_mem #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_tree_mem (
        .i_clk(i_clk), .i_we(tree_we),
        .i_depth_waddr(depth_waddr), .i_depth_wdata(depth_wdata),
        .i_depth_raddr_a(depth_raddr_a), .i_depth_raddr_b(depth_raddr_b),
        .o_depth_rdata_a(depth_rdata_a), .o_depth_rdata_b(depth_rdata_b),
        .i_anc_wlvl(anc_wlvl), .i_anc_waddr(anc_waddr), .i_anc_wdata(anc_wdata),
        .i_anc_rlvl(anc_rlvl), .i_anc_raddr_a(anc_raddr_a),
        .i_anc_raddr_b(anc_raddr_b),
        .o_anc_rdata_a(anc_rdata_a), .o_anc_rdata_b(anc_rdata_b)
    );
endmodule
`default_nettype wire

FILE: rtl/lca_edge_mem.sv
// Adjacency list heads, edge slots and walk stack memories.
`default_nettype none
module lca_edge_mem #(
    parameter int MAX_NODES = 1024
) (
    input  wire                                      i_clk,
    input  lca_pkg::t_edge_we                        i_we,
    input  wire  [$clog2(MAX_NODES+1)-1:0]           i_head_waddr,
    input  wire  [$clog2(2*MAX_NODES):0]             i_head_wdata,
    input  wire  [$clog2(MAX_NODES+1)-1:0]           i_head_raddr,
    output logic [$clog2(2*MAX_NODES):0]             o_head_rdata,
    input  wire  [$clog2(2*MAX_NODES)-1:0]           i_slot_waddr,
    input  wire  [$clog2(MAX_NODES+1)-1:0]           i_target_wdata,
    input  wire  [$clog2(2*MAX_NODES):0]             i_link_wdata,
    input  wire  [$clog2(2*MAX_NODES)-1:0]           i_slot_raddr,
    output logic [$clog2(MAX_NODES+1)-1:0]           o_target_rdata,
    output logic [$clog2(2*MAX_NODES):0]             o_link_rdata,
    input  wire  [$clog2(MAX_NODES)-1:0]             i_stk_waddr,
    input  wire  [2*$clog2(MAX_NODES+1)+$clog2(2*MAX_NODES):0] i_stk_wdata,
    input  wire  [$clog2(MAX_NODES)-1:0]             i_stk_raddr,
    output logic [2*$clog2(MAX_NODES+1)+$clog2(2*MAX_NODES):0] o_stk_rdata
);
    localparam int AW    = $clog2(MAX_NODES + 1);
    localparam int SLOTS = 2 * MAX_NODES;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = SW + 1;
    localparam int EW    = 2 * AW + LW;

    logic [LW-1:0] r_head_mem   [MAX_NODES+1];
    logic [AW-1:0] r_target_mem [SLOTS];
    logic [LW-1:0] r_link_mem   [SLOTS];
    logic [EW-1:0] r_stk_mem    [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_we.head_we) begin
            r_head_mem[i_head_waddr] <= i_head_wdata;
        end
        o_head_rdata <= r_head_mem[i_head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.slot_we) begin
            r_target_mem[i_slot_waddr] <= i_target_wdata;
            r_link_mem[i_slot_waddr]   <= i_link_wdata;
        end
        o_target_rdata <= r_target_mem[i_slot_raddr];
        o_link_rdata   <= r_link_mem[i_slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.stk_we) begin
            r_stk_mem[i_stk_waddr] <= i_stk_wdata;
        end
        o_stk_rdata <= r_stk_mem[i_stk_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/lca_tree_mem.sv
// Node depth and per-level ancestor memories.
`default_nettype none
module lca_tree_mem #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  wire                                   i_clk,
    input  lca_pkg::t_tree_we                     i_we,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_depth_waddr,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_depth_wdata,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_depth_raddr_a,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_depth_raddr_b,
    output logic [$clog2(MAX_NODES+1)-1:0]        o_depth_rdata_a,
    output logic [$clog2(MAX_NODES+1)-1:0]        o_depth_rdata_b,
    input  wire  [((LIFT_LEVELS>1)?$clog2(LIFT_LEVELS):1)-1:0] i_anc_wlvl,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_anc_waddr,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_anc_wdata,
    input  wire  [((LIFT_LEVELS>1)?$clog2(LIFT_LEVELS):1)-1:0] i_anc_rlvl,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_anc_raddr_a,
    input  wire  [$clog2(MAX_NODES+1)-1:0]        i_anc_raddr_b,
    output logic [$clog2(MAX_NODES+1)-1:0]        o_anc_rdata_a,
    output logic [$clog2(MAX_NODES+1)-1:0]        o_anc_rdata_b
);
    localparam int AW = $clog2(MAX_NODES + 1);

    logic [AW-1:0] r_depth_mem [MAX_NODES+1];
    logic [AW-1:0] r_anc_mem   [LIFT_LEVELS][MAX_NODES+1];

    always_ff @(posedge i_clk) begin
        if (i_we.clear) begin
            r_depth_mem[i_depth_waddr] <= '0;
        end else if (i_we.depth_we) begin
            r_depth_mem[i_depth_waddr] <= i_depth_wdata;
        end
        o_depth_rdata_a <= r_depth_mem[i_depth_raddr_a];
        o_depth_rdata_b <= r_depth_mem[i_depth_raddr_b];
    end

    // Clear writes one row across every level bank.
    always_ff @(posedge i_clk) begin
        if (i_we.clear) begin
            for (int l = 0; l < LIFT_LEVELS; l++) begin
                r_anc_mem[l][i_depth_waddr] <= '0;
            end
        end else if (i_we.anc_we) begin
            r_anc_mem[i_anc_wlvl][i_anc_waddr] <= i_anc_wdata;
        end
        o_anc_rdata_a <= r_anc_mem[i_anc_rlvl][i_anc_raddr_a];
        o_anc_rdata_b <= r_anc_mem[i_anc_rlvl][i_anc_raddr_b];
    end
endmodule
`default_nettype wire

FILE: rtl/lca_seq.sv
// Sequencer: edge insert, tree build, table fill and lifting query.
`default_nettype none
module lca_seq #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_op,
    input  wire  [lca_pkg::NODE_W-1:0]   i_node_a,
    input  wire  [lca_pkg::NODE_W-1:0]   i_node_b,
    input  wire  [lca_pkg::CFG_W-1:0]    i_node_count,
    input  wire  [lca_pkg::CFG_W-1:0]    i_root_node,
    input  wire                          i_cfg_wr,
    input  wire                          i_out_free,
    output logic                         o_res_load,
    output logic [lca_pkg::NODE_W-1:0]   o_res_node,
    output lca_pkg::t_edge_we            o_edge_we,
    output logic [$clog2(MAX_NODES+1)-1:0] o_head_waddr,
    output logic [$clog2(2*MAX_NODES):0]   o_head_wdata,
    output logic [$clog2(MAX_NODES+1)-1:0] o_head_raddr,
    input  wire  [$clog2(2*MAX_NODES):0]   i_head_rdata,
    output logic [$clog2(2*MAX_NODES)-1:0] o_slot_waddr,
    output logic [$clog2(MAX_NODES+1)-1:0] o_target_wdata,
    output logic [$clog2(2*MAX_NODES):0]   o_link_wdata,
    output logic [$clog2(2*MAX_NODES)-1:0] o_slot_raddr,
    input  wire  [$clog2(MAX_NODES+1)-1:0] i_target_rdata,
    input  wire  [$clog2(2*MAX_NODES):0]   i_link_rdata,
    output logic [$clog2(MAX_NODES)-1:0]   o_stk_waddr,
    output logic [2*$clog2(MAX_NODES+1)+$clog2(2*MAX_NODES):0] o_stk_wdata,
    output logic [$clog2(MAX_NODES)-1:0]   o_stk_raddr,
    input  wire  [2*$clog2(MAX_NODES+1)+$clog2(2*MAX_NODES):0] i_stk_rdata,
    output lca_pkg::t_tree_we            o_tree_we,
    output logic [$clog2(MAX_NODES+1)-1:0] o_depth_waddr,
    output logic [$clog2(MAX_NODES+1)-1:0] o_depth_wdata,
    output logic [$clog2(MAX_NODES+1)-1:0] o_depth_raddr_a,
    output logic [$clog2(MAX_NODES+1)-1:0] o_depth_raddr_b,
    input  wire  [$clog2(MAX_NODES+1)-1:0] i_depth_rdata_a,
    input  wire  [$clog2(MAX_NODES+1)-1:0] i_depth_rdata_b,
    output logic [((LIFT_LEVELS>1)?$clog2(LIFT_LEVELS):1)-1:0] o_anc_wlvl,
    output logic [$clog2(MAX_NODES+1)-1:0] o_anc_waddr,
    output logic [$clog2(MAX_NODES+1)-1:0] o_anc_wdata,
    output logic [((LIFT_LEVELS>1)?$clog2(LIFT_LEVELS):1)-1:0] o_anc_rlvl,
    output logic [$clog2(MAX_NODES+1)-1:0] o_anc_raddr_a,
    output logic [$clog2(MAX_NODES+1)-1:0] o_anc_raddr_b,
    input  wire  [$clog2(MAX_NODES+1)-1:0] i_anc_rdata_a,
    input  wire  [$clog2(MAX_NODES+1)-1:0] i_anc_rdata_b
);
    localparam int AW    = $clog2(MAX_NODES + 1);
    localparam int SLOTS = 2 * MAX_NODES;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = SW + 1;
    localparam int KW    = $clog2(MAX_NODES);
    localparam int LVW   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int TOP   = 1 << (LIFT_LEVELS - 1);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_E0    = 5'd2;
    localparam logic [4:0] S_E1    = 5'd3;
    localparam logic [4:0] S_E2    = 5'd4;
    localparam logic [4:0] S_E3    = 5'd5;
    localparam logic [4:0] S_BCLR  = 5'd6;
    localparam logic [4:0] S_BR0   = 5'd7;
    localparam logic [4:0] S_BR1   = 5'd8;
    localparam logic [4:0] S_WTOP  = 5'd9;
    localparam logic [4:0] S_WEDGE = 5'd10;
    localparam logic [4:0] S_WCHK  = 5'd11;
    localparam logic [4:0] S_WPOP  = 5'd12;
    localparam logic [4:0] S_F0    = 5'd13;
    localparam logic [4:0] S_F1    = 5'd14;
    localparam logic [4:0] S_F2    = 5'd15;
    localparam logic [4:0] S_Q0    = 5'd16;
    localparam logic [4:0] S_Q1    = 5'd17;
    localparam logic [4:0] S_QLIFT = 5'd18;
    localparam logic [4:0] S_QLD   = 5'd19;
    localparam logic [4:0] S_QD0   = 5'd20;
    localparam logic [4:0] S_QD1   = 5'd21;
    localparam logic [4:0] S_QF0   = 5'd22;
    localparam logic [4:0] S_QF1   = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    logic [4:0]     r_state, n_state;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_a, n_a;
    logic [AW-1:0]  r_b, n_b;
    logic [LW-1:0]  r_total, n_total;
    logic           r_tbl_ok, n_tbl_ok;
    logic [AW-1:0]  r_n, n_n;
    logic [AW-1:0]  r_root, n_root;
    logic [AW-1:0]  r_u, n_u;
    logic [LW-1:0]  r_lk, n_lk;
    logic [AW-1:0]  r_du, n_du;
    logic [AW-1:0]  r_v, n_v;
    logic [AW-1:0]  r_sp, n_sp;
    logic [LVW-1:0] r_lvl, n_lvl;
    logic [AW-1:0]  r_x, n_x;
    logic [AW-1:0]  r_y, n_y;
    logic [AW-1:0]  r_h, n_h;
    logic [AW-1:0]  r_res, n_res;

    logic           a_ok, b_ok, a_in, b_in;
    logic [LVW-1:0] low_bit;
    logic           fill_go;

    assign a_in = (32'(i_node_a) <= MAX_NODES);
    assign b_in = (32'(i_node_b) <= MAX_NODES);
    assign a_ok = a_in && (i_node_a != '0);
    assign b_ok = b_in && (i_node_b != '0);
    assign fill_go = (LIFT_LEVELS > 1) && (r_n != '0);

    // The lowest set bit of the remaining gap picks a level below the top one.
    always_comb begin
        low_bit = '0;
        for (int i = AW - 1; i >= 0; i--) begin
            if (r_h[i]) begin
                low_bit = LVW'(i);
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_node = lca_pkg::NODE_W'(r_res);

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_a = r_a; n_b = r_b;
        n_total = r_total; n_tbl_ok = r_tbl_ok; n_n = r_n; n_root = r_root;
        n_u = r_u; n_lk = r_lk; n_du = r_du; n_v = r_v; n_sp = r_sp;
        n_lvl = r_lvl; n_x = r_x; n_y = r_y; n_h = r_h; n_res = r_res;
        o_res_load = 1'b0;
        o_edge_we = '0;
        o_tree_we = '0;
        o_head_waddr = '0; o_head_wdata = '0; o_head_raddr = '0;
        o_slot_waddr = '0; o_target_wdata = '0; o_link_wdata = '0; o_slot_raddr = '0;
        o_stk_waddr = '0; o_stk_wdata = '0; o_stk_raddr = '0;
        o_depth_waddr = '0; o_depth_wdata = '0;
        o_depth_raddr_a = '0; o_depth_raddr_b = '0;
        o_anc_wlvl = '0; o_anc_waddr = '0; o_anc_wdata = '0;
        o_anc_rlvl = '0; o_anc_raddr_a = '0; o_anc_raddr_b = '0;
        if (i_cfg_wr) begin
            n_tbl_ok = 1'b0;
        end
        unique case (r_state)
            S_CLR: begin
                o_edge_we.head_we = 1'b1;
                o_head_waddr = r_idx;
                n_idx = r_idx + 1'b1;
                if (32'(r_idx) == MAX_NODES) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == lca_pkg::OP_EDGE) begin
                        n_tbl_ok = 1'b0;
                        n_a = AW'(i_node_a);
                        n_b = AW'(i_node_b);
                        if (a_ok && b_ok && (32'(r_total) + 2 <= SLOTS)) begin
                            n_state = S_E0;
                        end
                    end else begin
                        n_a = a_in ? AW'(i_node_a) : '0;
                        n_b = b_in ? AW'(i_node_b) : '0;
                        if (r_tbl_ok) begin
                            n_state = S_Q0;
                        end else begin
                            n_idx = '0;
                            n_n = (32'(i_node_count) > MAX_NODES) ? AW'(MAX_NODES)
                                                                  : AW'(i_node_count);
                            n_root = (32'(i_root_node) <= MAX_NODES) ? AW'(i_root_node)
                                                                     : '0;
                            n_state = S_BCLR;
                        end
                    end
                end
            end
            S_E0: begin
                o_head_raddr = r_a;
                n_state = S_E1;
            end
            S_E1: begin
                o_edge_we.slot_we = 1'b1;
                o_edge_we.head_we = 1'b1;
                o_slot_waddr = SW'(r_total);
                o_target_wdata = r_b;
                o_link_wdata = i_head_rdata;
                o_head_waddr = r_a;
                o_head_wdata = r_total + 1'b1;
                n_state = S_E2;
            end
            S_E2: begin
                o_head_raddr = r_b;
                n_state = S_E3;
            end
            S_E3: begin
                o_edge_we.slot_we = 1'b1;
                o_edge_we.head_we = 1'b1;
                o_slot_waddr = SW'(r_total + 1'b1);
                o_target_wdata = r_a;
                o_link_wdata = i_head_rdata;
                o_head_waddr = r_b;
                o_head_wdata = r_total + LW'(2);
                n_total = r_total + LW'(2);
                n_state = S_IDLE;
            end
            S_BCLR: begin
                o_tree_we.clear = 1'b1;
                o_depth_waddr = r_idx;
                n_idx = r_idx + 1'b1;
                if (32'(r_idx) == MAX_NODES) begin
                    n_lvl = LVW'(1);
                    n_idx = AW'(1);
                    if (32'(r_root) <= MAX_NODES && r_root != '0 && r_root <= r_n) begin
                        n_state = S_BR0;
                    end else if (fill_go) begin
                        n_state = S_F0;
                    end else begin
                        n_tbl_ok = 1'b1;
                        n_state = S_Q0;
                    end
                end
            end
            S_BR0: begin
                o_head_raddr = r_root;
                n_state = S_BR1;
            end
            S_BR1: begin
                o_tree_we.depth_we = 1'b1;
                o_depth_waddr = r_root;
                o_depth_wdata = AW'(1);
                n_u = r_root;
                n_lk = i_head_rdata;
                n_du = AW'(1);
                n_sp = AW'(1);
                n_state = S_WTOP;
            end
            S_WTOP: begin
                if (r_lk == '0) begin
                    // Top exhausted: drop it and restore the entry below, or end the walk at the root.
                    if (r_sp == AW'(1)) begin
                        if (fill_go) begin
                            n_state = S_F0;
                        end else begin
                            n_tbl_ok = 1'b1;
                            n_state = S_Q0;
                        end
                    end else begin
                        o_stk_raddr = KW'(r_sp - AW'(2));
                        n_state = S_WPOP;
                    end
                end else begin
                    o_slot_raddr = SW'(r_lk - 1'b1);
                    n_state = S_WEDGE;
                end
            end
            S_WPOP: begin
                {n_u, n_lk, n_du} = i_stk_rdata;
                n_sp = r_sp - 1'b1;
                n_state = S_WTOP;
            end
            S_WEDGE: begin
                n_v = i_target_rdata;
                n_lk = i_link_rdata;
                o_depth_raddr_a = i_target_rdata;
                o_head_raddr = i_target_rdata;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (r_v != '0 && r_v <= r_n && i_depth_rdata_a == '0
                    && 32'(r_sp) < MAX_NODES) begin
                    o_edge_we.stk_we = 1'b1;
                    o_stk_waddr = KW'(r_sp - 1'b1);
                    o_stk_wdata = {r_u, r_lk, r_du};
                    o_tree_we.anc_we = 1'b1;
                    o_anc_waddr = r_v;
                    o_anc_wdata = r_u;
                    o_tree_we.depth_we = 1'b1;
                    o_depth_waddr = r_v;
                    o_depth_wdata = r_du + 1'b1;
                    n_u = r_v;
                    n_lk = i_head_rdata;
                    n_du = r_du + 1'b1;
                    n_sp = r_sp + 1'b1;
                end
                n_state = S_WTOP;
            end
            S_F0: begin
                o_anc_rlvl = r_lvl - 1'b1;
                o_anc_raddr_a = r_idx;
                n_state = S_F1;
            end
            S_F1: begin
                o_anc_rlvl = r_lvl - 1'b1;
                o_anc_raddr_a = i_anc_rdata_a;
                n_state = S_F2;
            end
            S_F2: begin
                o_tree_we.anc_we = 1'b1;
                o_anc_wlvl = r_lvl;
                o_anc_waddr = r_idx;
                o_anc_wdata = i_anc_rdata_a;
                n_state = S_F0;
                if (r_idx == r_n) begin
                    n_idx = AW'(1);
                    if (32'(r_lvl) == LIFT_LEVELS - 1) begin
                        n_tbl_ok = 1'b1;
                        n_state = S_Q0;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_Q0: begin
                o_depth_raddr_a = r_a;
                o_depth_raddr_b = r_b;
                n_state = S_Q1;
            end
            S_Q1: begin
                if (i_depth_rdata_a < i_depth_rdata_b) begin
                    n_x = r_b; n_y = r_a;
                    n_h = i_depth_rdata_b - i_depth_rdata_a;
                end else begin
                    n_x = r_a; n_y = r_b;
                    n_h = i_depth_rdata_a - i_depth_rdata_b;
                end
                n_state = S_QLIFT;
            end
            S_QLIFT: begin
                if (32'(r_h) >= TOP) begin
                    o_anc_rlvl = LVW'(LIFT_LEVELS - 1);
                    o_anc_raddr_a = r_x;
                    n_h = r_h - AW'(TOP);
                    n_state = S_QLD;
                end else if (r_h != '0) begin
                    o_anc_rlvl = low_bit;
                    o_anc_raddr_a = r_x;
                    n_h = r_h & (r_h - 1'b1);
                    n_state = S_QLD;
                end else if (r_x == r_y) begin
                    n_res = r_x;
                    n_state = S_DONE;
                end else begin
                    n_lvl = LVW'(LIFT_LEVELS - 1);
                    n_state = S_QD0;
                end
            end
            S_QLD: begin
                n_x = i_anc_rdata_a;
                n_state = S_QLIFT;
            end
            S_QD0: begin
                o_anc_rlvl = r_lvl;
                o_anc_raddr_a = r_x;
                o_anc_raddr_b = r_y;
                n_state = S_QD1;
            end
            S_QD1: begin
                if (i_anc_rdata_a != i_anc_rdata_b) begin
                    n_x = i_anc_rdata_a;
                    n_y = i_anc_rdata_b;
                end
                if (r_lvl == '0) begin
                    n_state = S_QF0;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                    n_state = S_QD0;
                end
            end
            S_QF0: begin
                o_anc_raddr_a = r_x;
                n_state = S_QF1;
            end
            S_QF1: begin
                n_res = i_anc_rdata_a;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_total  <= '0;
            r_tbl_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_total  <= n_total;
            r_tbl_ok <= n_tbl_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_n <= n_n; r_root <= n_root;
        r_u <= n_u; r_lk <= n_lk; r_du <= n_du; r_v <= n_v; r_sp <= n_sp;
        r_lvl <= n_lvl; r_x <= n_x; r_y <= n_y; r_h <= n_h; r_res <= n_res;
    end
endmodule
`default_nettype wire

FILE: rtl/lca_chk.sv
// Port-level checker for the top level, with its bind.
`default_nettype none
`include "assert_macros.svh"
module lca_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         i_in_ready,
    input wire                         i_in_op,
    input wire                         o_out_valid,
    input wire                         o_out_ready,
    input wire [lca_pkg::NODE_W-1:0]   o_out_node
);
    logic in_acc, acc_edge, acc_query, out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign acc_edge  = in_acc && (i_in_op == lca_pkg::OP_EDGE);
    assign acc_query = in_acc && (i_in_op == lca_pkg::OP_QUERY);
    assign out_stall = o_out_valid && !o_out_ready;

    `LCA_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid && $stable(o_out_node))
    // A query always occupies the sequencer; a dropped edge may not.
    `LCA_ASSERT(a_busy_after_query, i_clk, i_rst_n, acc_query |=> !i_in_ready)
    `LCA_ASSERT(a_edge_silent, i_clk, i_rst_n, acc_edge |=> !$rose(o_out_valid))
    `LCA_ASSERT_NR(a_reset_busy, i_clk, !i_rst_n |=> !i_in_ready)
endmodule

bind lca_binary_lifting_top lca_chk u_lca_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_in_op(i_in.op),
    .o_out_valid(o_out.valid),
    .o_out_ready(o_out.ready),
    .o_out_node(o_out.ancestor_node)
);
`default_nettype wire
